// File: hdl/pvcs_pkg.sv
// Package for the vertex count solver: field widths, status codes and sequencer states.
// No dependencies.
`default_nettype none

package pvcs_pkg;

    localparam int unsigned MAX_VERTICES = 4095;

    localparam int FIELD_W  = 24;
    localparam int VS_W     = 25;
    localparam int PROD_W   = 2 * FIELD_W + 1;
    localparam int RAD_W    = 2 * VS_W;
    localparam int REM_W    = VS_W + 3;
    localparam int CNT_W    = $clog2(MAX_VERTICES + 3);
    localparam int CNT_OUT_W = 12;
    localparam int STAT_W   = 2;
    localparam int STEP_W   = $clog2(VS_W + 1);

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV,
        ST_ADJUST,
        ST_GCD_INIT,
        ST_GCD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/pong_vertex_count_solver.sv
// Vertex count solver top level: bit-serial square, square root, divide and gcd search.
// Depends on pvcs_pkg.
`default_nettype none

// One request at a time. A request with a zero field goes straight to the done state.
// Otherwise: shift-add squaring, bit-serial square root, restoring division of the
// width and then the height, parity adjustment, then the common-factor search: each
// gcd pass is a binary gcd taking one subtract or shift per cycle, after a set-up
// step and up to a final check, repeated once per growth of the larger count.
// The next request is taken while a finished result waits in the output register.
module pong_vertex_count_solver (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pvcs_pkg::FIELD_W-1:0]   s_width,
    input  wire logic [pvcs_pkg::FIELD_W-1:0]   s_height,
    input  wire logic [pvcs_pkg::FIELD_W-1:0]   s_spacing,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pvcs_pkg::VS_W-1:0]          m_vertex_spacing,
    output logic [pvcs_pkg::CNT_OUT_W-1:0]     m_x_vertices,
    output logic [pvcs_pkg::CNT_OUT_W-1:0]     m_y_vertices,
    output logic [pvcs_pkg::STAT_W-1:0]        m_result_status
);
    import pvcs_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [FIELD_W-1:0]  w_reg, w_next, h_reg, h_next, s_reg, s_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [VS_W-1:0]     root_reg, root_next;
    logic [VS_W-1:0]     vs_reg, vs_next;
    logic [FIELD_W-1:0]  q_reg, q_next;
    logic [VS_W-1:0]     drem_reg, drem_next;
    logic                div_h_reg, div_h_next;
    logic [CNT_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic [CNT_W-1:0]    ga_reg, ga_next, gb_reg, gb_next;
    logic                hi_x_reg, hi_x_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;

    logic                m_valid_reg, m_valid_next;
    logic [VS_W-1:0]     m_vs_reg, m_vs_next;
    logic [CNT_OUT_W-1:0] m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic [STAT_W-1:0]   m_stat_reg, m_stat_next;

    // datapath steps
    logic [VS_W-1:0]     mul_upper;
    logic [PROD_W-1:0]   prod_step;
    logic [REM_W+1:0]    rem_sh, trial;
    logic                root_ge;
    logic [REM_W-1:0]    rem_step;
    logic [VS_W-1:0]     root_step;
    logic [VS_W:0]       div_t;
    logic                div_ge;
    logic [VS_W-1:0]     drem_step;
    logic [FIELD_W-1:0]  q_step;
    logic [VS_W-1:0]     cnt_full;
    logic                cnt_over;
    logic [CNT_W-1:0]    x_adj, y_adj, hi_adj, hi_grow;
    logic                hi_x_adj;

    always_comb begin
        mul_upper = prod_reg[PROD_W-1:FIELD_W] + (prod_reg[0] ? {1'b0, s_reg} : '0);
        prod_step = {1'b0, mul_upper, prod_reg[FIELD_W-1:1]};

        rem_sh    = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {3'b000, root_reg, 2'b01};
        root_ge   = rem_sh >= trial;
        rem_step  = root_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_step = {root_reg[VS_W-2:0], root_ge};

        div_t     = {drem_reg, q_reg[FIELD_W-1]};
        div_ge    = div_t >= {1'b0, vs_reg};
        drem_step = div_ge ? VS_W'(div_t - {1'b0, vs_reg}) : VS_W'(div_t);
        q_step    = {q_reg[FIELD_W-2:0], div_ge};
        cnt_full  = {1'b0, q_step} + VS_W'(drem_step != '0);
        cnt_over  = cnt_full > VS_W'(MAX_VERTICES);

        x_adj = x_reg;
        y_adj = y_reg;
        if (x_reg[0] == y_reg[0]) begin
            if (x_reg >= y_reg) begin
                y_adj = y_reg + CNT_W'(1);
            end else begin
                x_adj = x_reg + CNT_W'(1);
            end
        end
        hi_x_adj = x_adj >= y_adj;
        hi_adj   = hi_x_adj ? x_adj : y_adj;
        hi_grow  = (hi_x_reg ? x_reg : y_reg) + CNT_W'(2);
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        s_next       = s_reg;
        prod_next    = prod_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        vs_next      = vs_reg;
        q_next       = q_reg;
        drem_next    = drem_reg;
        div_h_next   = div_h_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        hi_x_next    = hi_x_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg;
        m_vs_next    = m_vs_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_stat_next  = m_stat_reg;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    w_next    = s_width;
                    h_next    = s_height;
                    s_next    = s_spacing;
                    prod_next = {{(PROD_W-FIELD_W){1'b0}}, s_spacing};
                    cnt_next  = '0;
                    stat_next = STATUS_OK;
                    if (s_width == '0 || s_height == '0 || s_spacing == '0) begin
                        stat_next  = STATUS_ZERO;
                        vs_next    = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                prod_next = prod_step;
                cnt_next  = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(FIELD_W - 1)) begin
                    rad_next   = RAD_W'({prod_step[PROD_W-2:0], 1'b0});
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                rem_next  = rem_step;
                root_next = root_step;
                cnt_next  = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(VS_W - 1)) begin
                    // round up when the remainder exceeds the root
                    vs_next    = root_step + VS_W'(rem_step > REM_W'(root_step));
                    q_next     = w_reg;
                    drem_next  = '0;
                    div_h_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                q_next    = q_step;
                drem_next = drem_step;
                cnt_next  = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(FIELD_W - 1)) begin
                    cnt_next = '0;
                    if (cnt_over) begin
                        stat_next  = STATUS_OVER;
                        state_next = ST_DONE;
                    end else if (!div_h_reg) begin
                        x_next     = CNT_W'(cnt_full);
                        q_next     = h_reg;
                        drem_next  = '0;
                        div_h_next = 1'b1;
                    end else begin
                        y_next     = CNT_W'(cnt_full);
                        state_next = ST_ADJUST;
                    end
                end
            end
            ST_ADJUST: begin
                x_next    = x_adj;
                y_next    = y_adj;
                hi_x_next = hi_x_adj;
                if (hi_adj > CNT_W'(MAX_VERTICES)) begin
                    stat_next  = STATUS_OVER;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_GCD_INIT;
                end
            end
            ST_GCD_INIT: begin
                // counts differ in parity: keep the odd one in ga
                if (x_reg[0]) begin
                    ga_next = x_reg;
                    gb_next = y_reg;
                end else begin
                    ga_next = y_reg;
                    gb_next = x_reg;
                end
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (gb_reg == '0) begin
                    if (ga_reg == CNT_W'(1)) begin
                        state_next = ST_DONE;
                    end else if (hi_grow > CNT_W'(MAX_VERTICES)) begin
                        stat_next  = STATUS_OVER;
                        state_next = ST_DONE;
                    end else begin
                        if (hi_x_reg) begin
                            x_next = hi_grow;
                        end else begin
                            y_next = hi_grow;
                        end
                        state_next = ST_GCD_INIT;
                    end
                end else if (!gb_reg[0]) begin
                    gb_next = {1'b0, gb_reg[CNT_W-1:1]};
                end else if (ga_reg > gb_reg) begin
                    ga_next = gb_reg;
                    gb_next = ga_reg - gb_reg;
                end else begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_vs_next    = vs_reg;
                    m_stat_next  = stat_reg;
                    m_x_next     = (stat_reg == STATUS_OK) ? x_reg[CNT_OUT_W-1:0] : '0;
                    m_y_next     = (stat_reg == STATUS_OK) ? y_reg[CNT_OUT_W-1:0] : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        s_reg      <= s_next;
        prod_reg   <= prod_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        vs_reg     <= vs_next;
        q_reg      <= q_next;
        drem_reg   <= drem_next;
        div_h_reg  <= div_h_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        hi_x_reg   <= hi_x_next;
        stat_reg   <= stat_next;
        m_vs_reg   <= m_vs_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_vertex_spacing = m_vs_reg;
    assign m_x_vertices     = m_x_reg;
    assign m_y_vertices     = m_y_reg;
    assign m_result_status  = m_stat_reg;

endmodule

`default_nettype wire
